>>> hdl/frustum_box_cull_test_assert.svh
// assertion macros for the frustum cull block
// included by the rtl files that carry concurrent checks, no other dependencies
`ifndef FRUSTUM_BOX_CULL_TEST_ASSERT_SVH
`define FRUSTUM_BOX_CULL_TEST_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define FBC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("frustum cull check failed");

// next-cycle implication, disabled while reset is low
`define FBC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("frustum cull check failed");

`endif

>>> hdl/fbc_pkg.sv
// shared constants, function codes and control struct for the frustum cull block
// no dependencies
`default_nettype none

package fbc_pkg;

    localparam int PLANES_DEF      = 6;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FIELD_WIDTH     = 32;
    localparam int SLOT_WIDTH      = 3;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_BOX   = 2'd1;
    localparam logic [1:0] FUNC_FLAT  = 2'd2;
    localparam logic [1:0] FUNC_POINT = 2'd3;

    // six products per plane: x min/max, y min/max, z min/max
    localparam logic [2:0] STEP_LAST = 3'd5;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [2:0] CORNER_LAST_POINT = 3'd0;
    localparam logic [2:0] CORNER_LAST_FLAT  = 3'd3;
    localparam logic [2:0] CORNER_LAST_BOX   = 3'd7;

    typedef struct packed {
        logic       issue;
        logic [2:0] step;
        logic       flat;
        logic [2:0] corner;
    } fbc_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/fbc_plane_regs.sv
// plane storage: outward normal and reference point for each plane slot
// depends on fbc_pkg
`default_nettype none

module fbc_plane_regs #(
    parameter int PLANES      = fbc_pkg::PLANES_DEF,
    parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF,
    localparam int PW         = (PLANES > 1) ? $clog2(PLANES) : 1
) (
    input  wire                          clk,
    input  wire                          wr_en,
    input  wire  [PW-1:0]                wr_idx,
    input  wire  signed [COORD_WIDTH-1:0] wr_n_x,
    input  wire  signed [COORD_WIDTH-1:0] wr_n_y,
    input  wire  signed [COORD_WIDTH-1:0] wr_n_z,
    input  wire  signed [COORD_WIDTH-1:0] wr_r_x,
    input  wire  signed [COORD_WIDTH-1:0] wr_r_y,
    input  wire  signed [COORD_WIDTH-1:0] wr_r_z,
    input  wire  [PW-1:0]                rd_idx,
    output logic signed [COORD_WIDTH-1:0] rd_n_x,
    output logic signed [COORD_WIDTH-1:0] rd_n_y,
    output logic signed [COORD_WIDTH-1:0] rd_n_z,
    output logic signed [COORD_WIDTH-1:0] rd_r_x,
    output logic signed [COORD_WIDTH-1:0] rd_r_y,
    output logic signed [COORD_WIDTH-1:0] rd_r_z
);

    logic signed [COORD_WIDTH-1:0] n_x_reg [PLANES];
    logic signed [COORD_WIDTH-1:0] n_y_reg [PLANES];
    logic signed [COORD_WIDTH-1:0] n_z_reg [PLANES];
    logic signed [COORD_WIDTH-1:0] r_x_reg [PLANES];
    logic signed [COORD_WIDTH-1:0] r_y_reg [PLANES];
    logic signed [COORD_WIDTH-1:0] r_z_reg [PLANES];

    // contents are undefined until a slot is loaded
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            n_x_reg[wr_idx] <= wr_n_x;
            n_y_reg[wr_idx] <= wr_n_y;
            n_z_reg[wr_idx] <= wr_n_z;
            r_x_reg[wr_idx] <= wr_r_x;
            r_y_reg[wr_idx] <= wr_r_y;
            r_z_reg[wr_idx] <= wr_r_z;
        end
    end

    assign rd_n_x = n_x_reg[rd_idx];
    assign rd_n_y = n_y_reg[rd_idx];
    assign rd_n_z = n_z_reg[rd_idx];
    assign rd_r_x = r_x_reg[rd_idx];
    assign rd_r_y = r_y_reg[rd_idx];
    assign rd_r_z = r_z_reg[rd_idx];

endmodule

`default_nettype wire

>>> hdl/fbc_dot_unit.sv
// shared subtract/multiply unit and corner summing for the plane distance tests
// depends on fbc_pkg
`default_nettype none

module fbc_dot_unit #(
    parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire  fbc_pkg::fbc_ctrl_t     ctrl,
    input  wire  signed [COORD_WIDTH-1:0] a_x,
    input  wire  signed [COORD_WIDTH-1:0] a_y,
    input  wire  signed [COORD_WIDTH-1:0] a_z,
    input  wire  signed [COORD_WIDTH-1:0] b_x,
    input  wire  signed [COORD_WIDTH-1:0] b_y,
    input  wire  signed [COORD_WIDTH-1:0] b_z,
    input  wire  signed [COORD_WIDTH-1:0] n_x,
    input  wire  signed [COORD_WIDTH-1:0] n_y,
    input  wire  signed [COORD_WIDTH-1:0] n_z,
    input  wire  signed [COORD_WIDTH-1:0] r_x,
    input  wire  signed [COORD_WIDTH-1:0] r_y,
    input  wire  signed [COORD_WIDTH-1:0] r_z,
    output logic                         outside
);

    localparam int W  = COORD_WIDTH;
    localparam int PRW = 2 * W + 1;
    localparam int SW  = 2 * W + 3;

    logic [1:0]           axis;
    logic signed [W-1:0]  p_sel;
    logic signed [W-1:0]  r_sel;
    logic signed [W-1:0]  n_sel;
    logic signed [W:0]    diff_next;

    logic signed [W-1:0]  n_reg;
    logic signed [W:0]    diff_reg;
    logic                 wr_reg;
    logic [2:0]           wr_step_reg;
    logic signed [PRW-1:0] prod;

    logic signed [PRW-1:0] tx_a_reg, tx_b_reg;
    logic signed [PRW-1:0] ty_a_reg, ty_b_reg;
    logic signed [PRW-1:0] tz_a_reg, tz_b_reg;

    logic signed [PRW-1:0] term_x, term_y, term_z;
    logic signed [SW-1:0]  sum;

    assign axis = ctrl.step[2:1];

    // operand select: step bit 0 picks max over min, flat test forces y to zero
    always_comb
    begin
        unique case (axis)
            fbc_pkg::AXIS_X:
            begin
                p_sel = ctrl.step[0] ? b_x : a_x;
                r_sel = r_x;
                n_sel = n_x;
            end
            fbc_pkg::AXIS_Y:
            begin
                p_sel = ctrl.flat ? '0 : (ctrl.step[0] ? b_y : a_y);
                r_sel = r_y;
                n_sel = n_y;
            end
            fbc_pkg::AXIS_Z:
            begin
                p_sel = ctrl.step[0] ? b_z : a_z;
                r_sel = r_z;
                n_sel = n_z;
            end
            default:
            begin
                p_sel = '0;
                r_sel = '0;
                n_sel = '0;
            end
        endcase
    end

    assign diff_next = {p_sel[W-1], p_sel} - {r_sel[W-1], r_sel};

    always_ff @(posedge clk)
    begin
        n_reg       <= n_sel;
        diff_reg    <= diff_next;
        wr_step_reg <= ctrl.step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wr_reg <= 1'b0;
        else
            wr_reg <= ctrl.issue;
    end

    assign prod = n_reg * diff_reg;

    always_ff @(posedge clk)
    begin
        if (wr_reg)
        begin
            unique case (wr_step_reg)
                3'd0:    tx_a_reg <= prod;
                3'd1:    tx_b_reg <= prod;
                3'd2:    ty_a_reg <= prod;
                3'd3:    ty_b_reg <= prod;
                3'd4:    tz_a_reg <= prod;
                3'd5:    tz_b_reg <= prod;
                default: ;
            endcase
        end
    end

    // corner bits: x max when bit0 xor bit1, z max on bit1, y max on bit2
    assign term_x = (ctrl.corner[0] ^ ctrl.corner[1]) ? tx_b_reg : tx_a_reg;
    assign term_y = ctrl.corner[2] ? ty_b_reg : ty_a_reg;
    assign term_z = ctrl.corner[1] ? tz_b_reg : tz_a_reg;

    assign sum = SW'(term_x) + SW'(term_y) + SW'(term_z);

    // zero distance counts as outside
    assign outside = ~sum[SW-1];

endmodule

`default_nettype wire

>>> hdl/frustum_box_cull_test.sv
// top level of the frustum cull block: request handshake, sequencer, result register
// depends on fbc_pkg, fbc_plane_regs, fbc_dot_unit and frustum_box_cull_test_assert.svh
`default_nettype none

`include "frustum_box_cull_test_assert.svh"

// A plane load is taken while the block is idle and leaves it idle and ready. A test
// runs plane by plane through one shared subtract-and-multiply unit: for each plane the
// six axis products issue one per step in S_MUL, S_DRAIN lets the multiplier drain, and
// S_CORNER then checks one corner per cycle (one for a point, up to four flat, up to
// eight for a box). A plane stops at its first inside corner and the test stops at the
// first plane that culls. The next request is taken once the result has moved into the
// output register. A finished result waits in the output register while the next
// request is taken.
module frustum_box_cull_test #(
    parameter int PLANES      = fbc_pkg::PLANES_DEF,
    parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 item_valid,
    output logic                                item_stall,
    input  wire  [1:0]                          func,
    input  wire  [fbc_pkg::SLOT_WIDTH-1:0]      plane_slot,
    input  wire  signed [fbc_pkg::FIELD_WIDTH-1:0] first_x,
    input  wire  signed [fbc_pkg::FIELD_WIDTH-1:0] first_y,
    input  wire  signed [fbc_pkg::FIELD_WIDTH-1:0] first_z,
    input  wire  signed [fbc_pkg::FIELD_WIDTH-1:0] second_x,
    input  wire  signed [fbc_pkg::FIELD_WIDTH-1:0] second_y,
    input  wire  signed [fbc_pkg::FIELD_WIDTH-1:0] second_z,
    output logic                                result_valid,
    input  wire                                 result_stall,
    output logic                                culled
);

    localparam int W  = COORD_WIDTH;
    localparam int PW = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int IW = (PW > fbc_pkg::SLOT_WIDTH) ? PW : fbc_pkg::SLOT_WIDTH;
    localparam int CW = (PW + 1 > fbc_pkg::SLOT_WIDTH) ? PW + 1 : fbc_pkg::SLOT_WIDTH;
    localparam logic [PW-1:0] PLANE_LAST = PW'(PLANES - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_CORNER = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [PW-1:0] plane_reg, plane_next;
    logic [2:0]    step_reg, step_next;
    logic [2:0]    corner_reg, corner_next;
    logic          culled_pend_reg, culled_pend_next;
    logic          result_valid_reg, result_valid_next;
    logic          culled_reg, culled_next;

    logic [2:0]    corner_last_reg;
    logic          flat_reg;
    logic signed [W-1:0] a_x_reg, a_y_reg, a_z_reg;
    logic signed [W-1:0] b_x_reg, b_y_reg, b_z_reg;

    logic          item_acc;
    logic          test_acc;
    logic          slot_ok;
    logic          load_we;
    logic          res_free;
    logic          outside;
    logic [IW-1:0] slot_ext;

    logic signed [W-1:0] in_a_x, in_a_y, in_a_z;
    logic signed [W-1:0] in_b_x, in_b_y, in_b_z;
    logic signed [W-1:0] pl_n_x, pl_n_y, pl_n_z;
    logic signed [W-1:0] pl_r_x, pl_r_y, pl_r_z;

    fbc_pkg::fbc_ctrl_t ctrl;

    assign item_stall = (state_reg != S_IDLE);
    assign item_acc   = item_valid && !item_stall;
    assign test_acc   = item_acc && (func != fbc_pkg::FUNC_LOAD);
    assign slot_ok    = (CW'(plane_slot) < CW'(PLANES));
    assign load_we    = item_acc && (func == fbc_pkg::FUNC_LOAD) && slot_ok;
    assign slot_ext   = IW'(plane_slot);
    assign res_free   = !result_valid_reg || !result_stall;

    // coordinates use the low bits, sign carried by the top kept bit
    assign in_a_x = first_x[W-1:0];
    assign in_a_y = first_y[W-1:0];
    assign in_a_z = first_z[W-1:0];
    assign in_b_x = second_x[W-1:0];
    assign in_b_y = second_y[W-1:0];
    assign in_b_z = second_z[W-1:0];

    fbc_plane_regs #(
        .PLANES      (PLANES),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_planes (
        .clk    (clk),
        .wr_en  (load_we),
        .wr_idx (slot_ext[PW-1:0]),
        .wr_n_x (in_a_x),
        .wr_n_y (in_a_y),
        .wr_n_z (in_a_z),
        .wr_r_x (in_b_x),
        .wr_r_y (in_b_y),
        .wr_r_z (in_b_z),
        .rd_idx (plane_reg),
        .rd_n_x (pl_n_x),
        .rd_n_y (pl_n_y),
        .rd_n_z (pl_n_z),
        .rd_r_x (pl_r_x),
        .rd_r_y (pl_r_y),
        .rd_r_z (pl_r_z)
    );

    assign ctrl = '{
        issue:  (state_reg == S_MUL),
        step:   step_reg,
        flat:   flat_reg,
        corner: corner_reg
    };

    fbc_dot_unit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dot (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .a_x     (a_x_reg),
        .a_y     (a_y_reg),
        .a_z     (a_z_reg),
        .b_x     (b_x_reg),
        .b_y     (b_y_reg),
        .b_z     (b_z_reg),
        .n_x     (pl_n_x),
        .n_y     (pl_n_y),
        .n_z     (pl_n_z),
        .r_x     (pl_r_x),
        .r_y     (pl_r_y),
        .r_z     (pl_r_z),
        .outside (outside)
    );

    // request capture for tests
    always_ff @(posedge clk)
    begin
        if (test_acc)
        begin
            a_x_reg  <= in_a_x;
            a_y_reg  <= in_a_y;
            a_z_reg  <= in_a_z;
            b_x_reg  <= in_b_x;
            b_y_reg  <= in_b_y;
            b_z_reg  <= in_b_z;
            flat_reg <= (func == fbc_pkg::FUNC_FLAT);
            unique case (func)
                fbc_pkg::FUNC_POINT: corner_last_reg <= fbc_pkg::CORNER_LAST_POINT;
                fbc_pkg::FUNC_FLAT:  corner_last_reg <= fbc_pkg::CORNER_LAST_FLAT;
                default:             corner_last_reg <= fbc_pkg::CORNER_LAST_BOX;
            endcase
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        plane_next       = plane_reg;
        step_next        = step_reg;
        corner_next      = corner_reg;
        culled_pend_next = culled_pend_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (test_acc)
                begin
                    state_next = S_MUL;
                    plane_next = '0;
                    step_next  = '0;
                end
            end
            S_MUL:
            begin
                if (step_reg == fbc_pkg::STEP_LAST)
                    state_next = S_DRAIN;
                else
                    step_next = step_reg + 3'd1;
            end
            S_DRAIN:
            begin
                state_next  = S_CORNER;
                corner_next = '0;
            end
            S_CORNER:
            begin
                if (outside)
                begin
                    if (corner_reg == corner_last_reg)
                    begin
                        culled_pend_next = 1'b1;
                        state_next       = S_DONE;
                    end
                    else
                        corner_next = corner_reg + 3'd1;
                end
                else if (plane_reg == PLANE_LAST)
                begin
                    // every plane has an inside corner
                    culled_pend_next = 1'b0;
                    state_next       = S_DONE;
                end
                else
                begin
                    plane_next = plane_reg + PW'(1);
                    step_next  = '0;
                    state_next = S_MUL;
                end
            end
            S_DONE:
            begin
                if (res_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if ((state_reg == S_DONE) && res_free)
        begin
            result_valid_next = 1'b1;
            culled_next       = culled_pend_reg;
        end
        else
        begin
            result_valid_next = result_valid_reg && result_stall;
            culled_next       = culled_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            plane_reg        <= '0;
            step_reg         <= '0;
            corner_reg       <= '0;
            culled_pend_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            plane_reg        <= plane_next;
            step_reg         <= step_next;
            corner_reg       <= corner_next;
            culled_pend_reg  <= culled_pend_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        culled_reg <= culled_next;
    end

    assign result_valid = result_valid_reg;
    assign culled       = culled_reg;

    `FBC_ASSERT_NXT(a_test_starts, clk, rst_n, test_acc, (state_reg == S_MUL) && (plane_reg == '0) && (step_reg == '0))
    `FBC_ASSERT_NXT(a_load_no_busy, clk, rst_n, item_acc && (func == fbc_pkg::FUNC_LOAD), state_reg == S_IDLE)
    `FBC_ASSERT_IMP(a_corner_range, clk, rst_n, state_reg == S_CORNER, corner_reg <= corner_last_reg)
    `FBC_ASSERT_IMP(a_step_range, clk, rst_n, state_reg == S_MUL, step_reg <= fbc_pkg::STEP_LAST)
    `FBC_ASSERT_NXT(a_result_out, clk, rst_n, (state_reg == S_DONE) && res_free, result_valid_reg && (culled_reg == $past(culled_pend_reg)))

endmodule

`default_nettype wire
